// ===== rtl/core/pvpc_pkg.sv =====
// Shared widths, codes and payload types of the point versus primitive classifier.
package pvpc_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int BOX_W      = COORD_BITS + 2;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int SQ_W       = 2 * COORD_BITS;
    localparam int DIST_W     = SQ_W + 2;
    localparam int DOT_W      = PROD_W + 2;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int MAG_W      = PROD_W;
    localparam int CRSQ_W     = 2 * MAG_W;
    localparam int LHS_W      = CRSQ_W;
    localparam int RAD_W      = COORD_BITS - 1;
    localparam int R2_W       = 2 * RAD_W;
    localparam int RHS_W      = R2_W + DIST_W;

    localparam int MODE_W     = 2;
    localparam int REL_W      = 2;
    localparam int FACE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COORD_BITS;

    localparam logic [MODE_W-1:0] MODE_SPHERE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BOX     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CAPSULE = 2'd2;

    localparam logic [REL_W-1:0] REL_OUTSIDE = 2'd0;
    localparam logic [REL_W-1:0] REL_SURFACE = 2'd1;
    localparam logic [REL_W-1:0] REL_INSIDE  = 2'd2;

    localparam logic [FACE_W-1:0] FACE_NX = 3'd0;
    localparam logic [FACE_W-1:0] FACE_PX = 3'd1;
    localparam logic [FACE_W-1:0] FACE_NY = 3'd2;
    localparam logic [FACE_W-1:0] FACE_PY = 3'd3;
    localparam logic [FACE_W-1:0] FACE_NZ = 3'd4;
    localparam logic [FACE_W-1:0] FACE_PZ = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_Z    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_Z   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 3'd7;

    // Axis 0 is x, 1 is y, 2 is z.
    typedef logic [2:0][COORD_BITS-1:0] coord3_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        coord3_t           first;
        coord3_t           second;
        logic [RAD_W-1:0]  radius;
    } cfg_t;

    // Products leaving the front end.
    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [R2_W-1:0]           r2;
        logic [REL_W-1:0]          box_rel;
        logic [FACE_W-1:0]         box_face;
        logic [2:0][SQ_W-1:0]      sqw;
        logic [2:0][SQ_W-1:0]      sqv;
        logic [2:0][SQ_W-1:0]      sqd;
        logic [2:0][PROD_W-1:0]    wd;
        logic [2:0][PROD_W-1:0]    vd;
        logic [2:0][PROD_W-1:0]    crp;
        logic [2:0][PROD_W-1:0]    crn;
    } prod_t;

    // Flags and wide squares leaving the reduction stages.
    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [REL_W-1:0]          box_rel;
        logic [FACE_W-1:0]         box_face;
        logic                      between;
        logic                      sa_lt;
        logic                      sa_eq;
        logic                      sb_lt;
        logic                      sb_eq;
        logic [2:0][CRSQ_W-1:0]    crsq;
        logic [RHS_W-1:0]          rhs;
    } red_t;

endpackage

// ===== rtl/core/pvpc_front.sv =====
// Front end: coordinate differences, then all narrow products and the box test.
module pvpc_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  pvpc_pkg::coord3_t in_point,
    input  pvpc_pkg::cfg_t   cfg,
    output logic             out_valid,
    input  logic             out_ready,
    output pvpc_pkg::prod_t  out_data
);
    import pvpc_pkg::*;

    typedef struct packed {
        logic [MODE_W-1:0]      mode;
        logic [RAD_W-1:0]       radius;
        logic [2:0][DIFF_W-1:0] w;
        logic [2:0][DIFF_W-1:0] v;
        logic [2:0][DIFF_W-1:0] d;
        logic [2:0][BOX_W-1:0]  dl;
        logic [2:0][BOX_W-1:0]  dh;
    } diff_t;

    diff_t a_next, a_reg;
    prod_t b_next, b_reg;
    logic  a_valid_reg, b_valid_reg;
    logic  a_en, b_en;

    // Stage A: differences against both configured points and the box bounds.
    always_comb begin
        a_next.mode   = cfg.mode;
        a_next.radius = cfg.radius;
        for (int i = 0; i < 3; i++) begin
            a_next.w[i]  = DIFF_W'($signed(in_point[i])) - DIFF_W'($signed(cfg.first[i]));
            a_next.v[i]  = DIFF_W'($signed(in_point[i])) - DIFF_W'($signed(cfg.second[i]));
            a_next.d[i]  = DIFF_W'($signed(cfg.second[i])) - DIFF_W'($signed(cfg.first[i]));
            a_next.dl[i] = BOX_W'($signed(in_point[i])) - BOX_W'($signed(cfg.first[i]))
                         + BOX_W'($signed(cfg.second[i]));
            a_next.dh[i] = BOX_W'($signed(cfg.first[i])) + BOX_W'($signed(cfg.second[i]))
                         - BOX_W'($signed(in_point[i]));
        end
    end

    // Stage B: products, radius square, box relation and nearest face.
    always_comb begin
        logic signed [PROD_W-1:0] sq_w, sq_v, sq_d;
        logic signed [BOX_W-1:0]  best;
        logic [FACE_W-1:0]        face;
        logic                     outside, on_bound;

        b_next.mode = a_reg.mode;
        b_next.r2   = R2_W'(a_reg.radius) * R2_W'(a_reg.radius);
        outside     = 1'b0;
        on_bound    = 1'b0;
        for (int i = 0; i < 3; i++) begin
            sq_w = $signed(a_reg.w[i]) * $signed(a_reg.w[i]);
            sq_v = $signed(a_reg.v[i]) * $signed(a_reg.v[i]);
            sq_d = $signed(a_reg.d[i]) * $signed(a_reg.d[i]);
            b_next.sqw[i] = sq_w[SQ_W-1:0];
            b_next.sqv[i] = sq_v[SQ_W-1:0];
            b_next.sqd[i] = sq_d[SQ_W-1:0];
            b_next.wd[i]  = $signed(a_reg.w[i]) * $signed(a_reg.d[i]);
            b_next.vd[i]  = $signed(a_reg.v[i]) * $signed(a_reg.d[i]);
            if (a_reg.dl[i][BOX_W-1] || a_reg.dh[i][BOX_W-1]) begin
                outside = 1'b1;
            end
            if (a_reg.dl[i] == '0 || a_reg.dh[i] == '0) begin
                on_bound = 1'b1;
            end
        end
        b_next.crp[0] = $signed(a_reg.w[1]) * $signed(a_reg.d[2]);
        b_next.crn[0] = $signed(a_reg.w[2]) * $signed(a_reg.d[1]);
        b_next.crp[1] = $signed(a_reg.w[2]) * $signed(a_reg.d[0]);
        b_next.crn[1] = $signed(a_reg.w[0]) * $signed(a_reg.d[2]);
        b_next.crp[2] = $signed(a_reg.w[0]) * $signed(a_reg.d[1]);
        b_next.crn[2] = $signed(a_reg.w[1]) * $signed(a_reg.d[0]);

        // Strict less-than keeps the lowest face on ties.
        best = $signed(a_reg.dl[0]);
        face = FACE_NX;
        if ($signed(a_reg.dh[0]) < best) begin
            best = $signed(a_reg.dh[0]);
            face = FACE_PX;
        end
        if ($signed(a_reg.dl[1]) < best) begin
            best = $signed(a_reg.dl[1]);
            face = FACE_NY;
        end
        if ($signed(a_reg.dh[1]) < best) begin
            best = $signed(a_reg.dh[1]);
            face = FACE_PY;
        end
        if ($signed(a_reg.dl[2]) < best) begin
            best = $signed(a_reg.dl[2]);
            face = FACE_NZ;
        end
        if ($signed(a_reg.dh[2]) < best) begin
            face = FACE_PZ;
        end
        b_next.box_face = face;
        b_next.box_rel  = outside ? REL_OUTSIDE : (on_bound ? REL_SURFACE : REL_INSIDE);
    end

    assign b_en     = !b_valid_reg || out_ready;
    assign a_en     = !a_valid_reg || b_en;
    assign in_ready = a_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_en) begin
                a_valid_reg <= in_valid;
            end
            if (b_en) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_en && in_valid) begin
            a_reg <= a_next;
        end
        if (b_en && a_valid_reg) begin
            b_reg <= b_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_reg;

endmodule

// ===== rtl/core/pvpc_reduce.sv =====
// Reduction: sums and cross product, then the end-sphere tests and the wide squares.
module pvpc_reduce (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  pvpc_pkg::prod_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output pvpc_pkg::red_t  out_data
);
    import pvpc_pkg::*;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [R2_W-1:0]       r2;
        logic [REL_W-1:0]      box_rel;
        logic [FACE_W-1:0]     box_face;
        logic [DIST_W-1:0]     sa;
        logic [DIST_W-1:0]     sb;
        logic [DIST_W-1:0]     dd;
        logic                  between;
        logic [2:0][MAG_W-1:0] crmag;
    } sum_t;

    sum_t c_next, c_reg;
    red_t d_next, d_reg;
    logic c_valid_reg, d_valid_reg;
    logic c_en, d_en;

    // Stage C: squared distances, dot products, the between flag and cross product magnitudes.
    always_comb begin
        logic signed [DOT_W-1:0]   dot_wd, dot_vd;
        logic signed [CROSS_W-1:0] cr;
        logic signed [CROSS_W-1:0] cr_neg;

        c_next.mode     = in_data.mode;
        c_next.r2       = in_data.r2;
        c_next.box_rel  = in_data.box_rel;
        c_next.box_face = in_data.box_face;
        c_next.sa = DIST_W'(in_data.sqw[0]) + DIST_W'(in_data.sqw[1]) + DIST_W'(in_data.sqw[2]);
        c_next.sb = DIST_W'(in_data.sqv[0]) + DIST_W'(in_data.sqv[1]) + DIST_W'(in_data.sqv[2]);
        c_next.dd = DIST_W'(in_data.sqd[0]) + DIST_W'(in_data.sqd[1]) + DIST_W'(in_data.sqd[2]);
        dot_wd = DOT_W'($signed(in_data.wd[0])) + DOT_W'($signed(in_data.wd[1]))
               + DOT_W'($signed(in_data.wd[2]));
        dot_vd = DOT_W'($signed(in_data.vd[0])) + DOT_W'($signed(in_data.vd[1]))
               + DOT_W'($signed(in_data.vd[2]));
        // Strictly past end A toward B, and strictly short of B.
        c_next.between = (c_next.dd != '0) && !dot_wd[DOT_W-1] && (dot_wd != '0)
                       && dot_vd[DOT_W-1];
        for (int i = 0; i < 3; i++) begin
            cr     = CROSS_W'($signed(in_data.crp[i])) - CROSS_W'($signed(in_data.crn[i]));
            cr_neg = -cr;
            c_next.crmag[i] = cr[CROSS_W-1] ? MAG_W'(cr_neg) : MAG_W'(cr);
        end
    end

    // Stage D: end-sphere compares, wide squares and the squared axis length scaled by r2.
    always_comb begin
        d_next.mode     = c_reg.mode;
        d_next.box_rel  = c_reg.box_rel;
        d_next.box_face = c_reg.box_face;
        d_next.between  = c_reg.between;
        d_next.sa_lt    = c_reg.sa < DIST_W'(c_reg.r2);
        d_next.sa_eq    = c_reg.sa == DIST_W'(c_reg.r2);
        d_next.sb_lt    = c_reg.sb < DIST_W'(c_reg.r2);
        d_next.sb_eq    = c_reg.sb == DIST_W'(c_reg.r2);
        for (int i = 0; i < 3; i++) begin
            d_next.crsq[i] = CRSQ_W'(c_reg.crmag[i]) * CRSQ_W'(c_reg.crmag[i]);
        end
        d_next.rhs = RHS_W'(c_reg.r2) * RHS_W'(c_reg.dd);
    end

    assign d_en     = !d_valid_reg || out_ready;
    assign c_en     = !c_valid_reg || d_en;
    assign in_ready = c_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (c_en) begin
                c_valid_reg <= in_valid;
            end
            if (d_en) begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (c_en && in_valid) begin
            c_reg <= c_next;
        end
        if (d_en && c_valid_reg) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_data  = d_reg;

endmodule

// ===== rtl/core/pvpc_decide.sv =====
// Final stage: body comparison, per-shape relation select and the result register.
module pvpc_decide (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pvpc_pkg::red_t                in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pvpc_pkg::REL_W-1:0]    out_relation,
    output logic [pvpc_pkg::FACE_W-1:0]   out_face
);
    import pvpc_pkg::*;

    logic [REL_W-1:0]  rel_next, rel_reg;
    logic [FACE_W-1:0] face_next, face_reg;
    logic              out_valid_reg;
    logic              e_en;

    always_comb begin
        logic [LHS_W-1:0] lhs;
        logic             body_in, body_on;

        lhs = LHS_W'(in_data.crsq[0]) + LHS_W'(in_data.crsq[1]) + LHS_W'(in_data.crsq[2]);
        body_in = in_data.between && (lhs < LHS_W'(in_data.rhs));
        body_on = in_data.between && (lhs == LHS_W'(in_data.rhs));
        face_next = FACE_NX;
        case (in_data.mode)
            MODE_SPHERE: begin
                rel_next = in_data.sa_lt ? REL_INSIDE :
                           (in_data.sa_eq ? REL_SURFACE : REL_OUTSIDE);
            end
            MODE_BOX: begin
                rel_next  = in_data.box_rel;
                face_next = in_data.box_face;
            end
            MODE_CAPSULE: begin
                if (body_in || in_data.sa_lt || in_data.sb_lt) begin
                    rel_next = REL_INSIDE;
                end else if (body_on || in_data.sa_eq || in_data.sb_eq) begin
                    rel_next = REL_SURFACE;
                end else begin
                    rel_next = REL_OUTSIDE;
                end
            end
            default: begin
                rel_next = REL_OUTSIDE;
            end
        endcase
    end

    assign e_en     = !out_valid_reg || out_ready;
    assign in_ready = e_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (e_en) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (e_en && in_valid) begin
            rel_reg  <= rel_next;
            face_reg <= face_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_relation = rel_reg;
    assign out_face     = face_reg;

    // Only box mode may name a face other than the first.
    a_face_box_only: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && e_en && (in_data.mode != MODE_BOX) |=> (face_reg == FACE_NX))
        else $error("nearest face set outside box mode");

endmodule

// ===== rtl/core/point_vs_primitive_classify.sv =====
// Top level of the point versus primitive classifier: config registers and the pipeline.
// Classifies one signed fixed-point query point per transaction against a sphere, an
// axis-aligned box or a capsule selected by shape_mode, reporting outside, on the surface
// or inside, plus the nearest face in box mode (ties go to -x, +x, -y, +y, -z, +z in
// that order). All tests are exact integer compares (squared distances for sphere and
// capsule), so a point exactly on a boundary always reads as surface. The datapath is a
// five-register pipeline (difference, product, reduction, wide square, decision) that
// takes one point every clock while m_ready does not stall the output. Every stage holds
// its own valid bit and advances when the stage after it is empty or moving, so bubbles
// collapse and the input keeps accepting while a finished result waits for m_ready, until
// the four stages behind the output register are full. Each multiplier sits within a
// single stage; the longest stage is the 34x34 square of the cross-product magnitude.
// Write the configuration registers only while no transaction is in flight.
module point_vs_primitive_classify (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [pvpc_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [pvpc_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    // query point transaction
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [pvpc_pkg::COORD_BITS-1:0] s_point_x,
    input  logic signed [pvpc_pkg::COORD_BITS-1:0] s_point_y,
    input  logic signed [pvpc_pkg::COORD_BITS-1:0] s_point_z,
    // result transaction
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [pvpc_pkg::REL_W-1:0]         m_relation,
    output logic [pvpc_pkg::FACE_W-1:0]        m_nearest_face
);
    import pvpc_pkg::*;

    cfg_t    cfg_next, cfg_reg;
    coord3_t point;

    prod_t   prod_data;
    logic    prod_valid, prod_ready;
    red_t    red_data;
    logic    red_valid, red_ready;

    // Decode a register write; unknown codes leave everything unchanged.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_SHAPE_MODE: cfg_next.mode      = cfg_wr_data[MODE_W-1:0];
                REG_FIRST_X:    cfg_next.first[0]  = cfg_wr_data[COORD_BITS-1:0];
                REG_FIRST_Y:    cfg_next.first[1]  = cfg_wr_data[COORD_BITS-1:0];
                REG_FIRST_Z:    cfg_next.first[2]  = cfg_wr_data[COORD_BITS-1:0];
                REG_SECOND_X:   cfg_next.second[0] = cfg_wr_data[COORD_BITS-1:0];
                REG_SECOND_Y:   cfg_next.second[1] = cfg_wr_data[COORD_BITS-1:0];
                REG_SECOND_Z:   cfg_next.second[2] = cfg_wr_data[COORD_BITS-1:0];
                REG_RADIUS:     cfg_next.radius    = cfg_wr_data[RAD_W-1:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    // Hold the configuration; everything clears to zero on reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Axis 0 is x.
    assign point = {s_point_z, s_point_y, s_point_x};

    // Differences, narrow products and the complete box test.
    pvpc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_point  (point),
        .cfg       (cfg_reg),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    // Sums, cross product, end-sphere compares and the wide squares.
    pvpc_reduce u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (red_valid),
        .out_ready (red_ready),
        .out_data  (red_data)
    );

    // Capsule body compare, shape select and the output register.
    pvpc_decide u_decide (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (red_valid),
        .in_ready     (red_ready),
        .in_data      (red_data),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_relation (m_relation),
        .out_face     (m_nearest_face)
    );

    // An empty output register lets the whole pipeline advance.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with an empty output register");

    a_relation_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_relation == REL_OUTSIDE || m_relation == REL_SURFACE
                     || m_relation == REL_INSIDE))
        else $error("relation code out of range");

    a_face_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_nearest_face <= FACE_PZ))
        else $error("nearest face code out of range");

endmodule
